### rtl/dpdm_pkg.sv
// shared types, codes and helpers for the dual-pass detection merge
package dpdm_pkg;

    localparam int MAX_OBJECTS_DEF = 64;
    localparam int CNT_W           = 7;
    localparam int SCORE_W         = 17;
    localparam int COORD_W         = 16;
    localparam int CLS_W           = 8;
    localparam int DRAIN_CYCLES    = 5;

    localparam logic [SCORE_W-1:0] Q_ONE   = 17'h10000;
    localparam logic [CNT_W-1:0]   CNT_SAT = 7'd127;

    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_HIGH    = 2'd1;
    localparam logic [1:0] KIND_LOW     = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [1:0] CFG_LOW_THR  = 2'd0;
    localparam logic [1:0] CFG_HIGH_THR = 2'd1;
    localparam logic [1:0] CFG_OVL_THR  = 2'd2;

    localparam logic [2:0] DISP_STARTED   = 3'd0;
    localparam logic [2:0] DISP_HIGH_KEPT = 3'd1;
    localparam logic [2:0] DISP_BELOW_LOW = 3'd2;
    localparam logic [2:0] DISP_DUPLICATE = 3'd3;
    localparam logic [2:0] DISP_REJECTED  = 3'd4;
    localparam logic [2:0] DISP_SUPPRESS  = 3'd5;
    localparam logic [2:0] DISP_CAP_DROP  = 3'd6;
    localparam logic [2:0] DISP_ACCEPTED  = 3'd7;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic issue;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic out_free;
    } t_sts;

    // max(0, hi - lo) on signed coordinates
    function automatic logic [COORD_W-1:0] span(input logic signed [COORD_W-1:0] lo,
                                                input logic signed [COORD_W-1:0] hi);
        logic signed [COORD_W:0] d;
        d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
        return (d > 0) ? d[COORD_W-1:0] : '0;
    endfunction

    // saturate a count to the 7-bit report width
    function automatic logic [CNT_W-1:0] sat7(input logic [8:0] v);
        return (v > 9'(CNT_SAT)) ? CNT_SAT : v[CNT_W-1:0];
    endfunction

endpackage

### rtl/dpdm_ctrl.sv
// controller: item sequencing, table scan and pipeline drain
module dpdm_ctrl #(
    parameter int MAX_OBJECTS = dpdm_pkg::MAX_OBJECTS_DEF,
    localparam int CW = $clog2(MAX_OBJECTS + 1),
    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  dpdm_pkg::t_sts  i_sts,
    input  logic [CW-1:0]   i_stored_count,
    output dpdm_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]   o_rd_addr
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [2:0]    r_drain, n_drain;

    assign o_stall   = (r_state != S_IDLE);
    assign o_rd_addr = r_idx[AW-1:0];

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_drain       = r_drain;
        o_cmd.capture = 1'b0;
        o_cmd.issue   = 1'b0;
        o_cmd.finish  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx   = '0;
                n_state = i_sts.needs_scan ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (r_idx == i_stored_count - CW'(1)) begin
                    n_drain = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 3'd1;
                if (r_drain == 3'(dpdm_pkg::DRAIN_CYCLES - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_drain <= n_drain;
        end
    end

endmodule

### rtl/dpdm_dp.sv
// datapath: config, box table, overlap pipeline, counters and result word
module dpdm_dp #(
    parameter int MAX_OBJECTS = dpdm_pkg::MAX_OBJECTS_DEF,
    localparam int CW = $clog2(MAX_OBJECTS + 1),
    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [16:0]           i_cfg_data,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_class_label,
    input  logic [16:0]           i_score,
    input  logic signed [15:0]    i_box_left,
    input  logic signed [15:0]    i_box_top,
    input  logic signed [15:0]    i_box_right,
    input  logic signed [15:0]    i_box_bottom,
    input  dpdm_pkg::t_cmd        i_cmd,
    input  logic [AW-1:0]         i_rd_addr,
    output dpdm_pkg::t_sts        o_sts,
    output logic [CW-1:0]         o_stored_count,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_disposition,
    output logic [6:0]            o_category_count,
    output logic [6:0]            o_tracker_count,
    output logic                  o_error_flag
);

    localparam int EW = 8 + 4 * 16;

    // configuration
    logic [16:0] r_low_thr, r_high_thr, r_ovl_thr;
    logic        cfg_ok;

    // held item
    logic [1:0]         r_kind;
    logic [7:0]         r_cls;
    logic [16:0]        r_score;
    logic signed [15:0] r_l, r_t, r_r, r_b;
    logic [31:0]        r_area_a;

    // table
    logic [EW-1:0] r_mem [MAX_OBJECTS];
    logic [EW-1:0] r_mem_q;
    logic [CW-1:0] r_stored, r_cand;

    // overlap pipeline
    logic               r_v1, r_v2, r_v3, r_v4, r_v5;
    logic               r_m2, r_m3, r_m4, r_m5;
    logic [15:0]        r_iw, r_ih, r_bw, r_bh;
    logic [31:0]        r_inter3, r_area_b, r_inter4;
    logic [32:0]        r_union;
    logic [47:0]        r_lhs;
    logic [49:0]        r_prod;
    logic               r_nz;
    logic               r_hit;
    logic signed [15:0] q_l, q_t, q_r, q_b;
    logic [7:0]         q_cls;
    logic signed [15:0] x1, y1, x2, y2;

    // counters and result
    logic [6:0] r_cnt [8];
    logic       r_ovalid;
    logic [2:0] r_odisp;
    logic [6:0] r_ocat, r_otrk;
    logic       r_oerr;

    logic          full_cand, err;
    logic [2:0]    disp;
    logic [6:0]    cnt_inc;
    logic [CW-1:0] cand_next;

    assign cfg_ok = (r_low_thr < r_high_thr) && (r_high_thr <= dpdm_pkg::Q_ONE)
                    && (r_ovl_thr <= dpdm_pkg::Q_ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= '0;
            r_high_thr <= dpdm_pkg::Q_ONE;
            r_ovl_thr  <= 17'h08000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dpdm_pkg::CFG_LOW_THR:  r_low_thr  <= i_cfg_data;
                dpdm_pkg::CFG_HIGH_THR: r_high_thr <= i_cfg_data;
                dpdm_pkg::CFG_OVL_THR:  r_ovl_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_cls   <= i_class_label;
            r_score <= i_score;
            r_l     <= i_box_left;
            r_t     <= i_box_top;
            r_r     <= i_box_right;
            r_b     <= i_box_bottom;
        end
        r_area_a <= 32'(dpdm_pkg::span(r_l, r_r)) * 32'(dpdm_pkg::span(r_t, r_b));
    end

    assign full_cand = (r_cand >= CW'(MAX_OBJECTS));

    always_comb begin
        o_sts.needs_scan = (r_kind == dpdm_pkg::KIND_LOW) && cfg_ok
                           && (r_score >= r_low_thr) && (r_stored != '0);
        o_sts.out_free   = !r_ovalid || !i_stall;
    end
    assign o_stored_count = r_stored;

    // table write on a stored high-pass box, registered read during the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && !err && (r_kind == dpdm_pkg::KIND_HIGH)
                && (r_stored < CW'(MAX_OBJECTS))) begin
            r_mem[r_stored[AW-1:0]] <= {r_cls, r_l, r_t, r_r, r_b};
        end
        if (i_cmd.issue) begin
            r_mem_q <= r_mem[i_rd_addr];
        end
    end

    assign {q_cls, q_l, q_t, q_r, q_b} = r_mem_q;
    assign x1 = (r_l > q_l) ? r_l : q_l;
    assign y1 = (r_t > q_t) ? r_t : q_t;
    assign x2 = (r_r < q_r) ? r_r : q_r;
    assign y2 = (r_b < q_b) ? r_b : q_b;

    always_ff @(posedge i_clk) begin
        r_iw     <= dpdm_pkg::span(x1, x2);
        r_ih     <= dpdm_pkg::span(y1, y2);
        r_bw     <= dpdm_pkg::span(q_l, q_r);
        r_bh     <= dpdm_pkg::span(q_t, q_b);
        r_m2     <= (q_cls == r_cls);
        r_inter3 <= 32'(r_iw) * 32'(r_ih);
        r_area_b <= 32'(r_bw) * 32'(r_bh);
        r_m3     <= r_m2;
        r_union  <= 33'(r_area_a) + 33'(r_area_b) - 33'(r_inter3);
        r_inter4 <= r_inter3;
        r_m4     <= r_m3;
        r_prod   <= 50'(r_ovl_thr) * 50'(r_union);
        r_lhs    <= {r_inter4, 16'h0000};
        r_nz     <= (r_union != '0);
        r_m5     <= r_m4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (i_cmd.capture) begin
                r_hit <= 1'b0;
            end else if (r_v5 && r_m5 && r_nz && ({2'b00, r_lhs} > r_prod)) begin
                r_hit <= 1'b1;
            end
        end
    end

    // disposition of the held item
    always_comb begin
        err = !cfg_ok || (r_kind == dpdm_pkg::KIND_UNKNOWN)
              || ((r_kind == dpdm_pkg::KIND_HIGH) && full_cand);
        case (r_kind)
            dpdm_pkg::KIND_FRAME: disp = dpdm_pkg::DISP_STARTED;
            dpdm_pkg::KIND_HIGH:  disp = dpdm_pkg::DISP_HIGH_KEPT;
            default: begin
                if (r_score < r_low_thr) begin
                    disp = dpdm_pkg::DISP_BELOW_LOW;
                end else if (r_score >= r_high_thr) begin
                    disp = r_hit ? dpdm_pkg::DISP_DUPLICATE : dpdm_pkg::DISP_REJECTED;
                end else if (r_hit) begin
                    disp = dpdm_pkg::DISP_SUPPRESS;
                end else if (full_cand) begin
                    disp = dpdm_pkg::DISP_CAP_DROP;
                end else begin
                    disp = dpdm_pkg::DISP_ACCEPTED;
                end
            end
        endcase
        cnt_inc = (r_cnt[disp] < dpdm_pkg::CNT_SAT) ? r_cnt[disp] + 7'd1 : r_cnt[disp];
        if (r_kind == dpdm_pkg::KIND_FRAME) begin
            cand_next = '0;
        end else if ((r_kind == dpdm_pkg::KIND_HIGH) || (disp == dpdm_pkg::DISP_ACCEPTED)) begin
            cand_next = r_cand + CW'(1);
        end else begin
            cand_next = r_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored <= '0;
            r_cand   <= '0;
            for (int k = 0; k < 8; k++) begin
                r_cnt[k] <= '0;
            end
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (err) begin
                    r_odisp <= dpdm_pkg::DISP_STARTED;
                    r_ocat  <= '0;
                    r_otrk  <= dpdm_pkg::sat7(9'(r_cand));
                    r_oerr  <= 1'b1;
                end else begin
                    r_odisp <= disp;
                    r_otrk  <= dpdm_pkg::sat7(9'(cand_next));
                    r_oerr  <= 1'b0;
                    r_cand  <= cand_next;
                    if (r_kind == dpdm_pkg::KIND_FRAME) begin
                        for (int k = 1; k < 8; k++) begin
                            r_cnt[k] <= '0;
                        end
                        r_cnt[0] <= 7'd1;
                        r_ocat   <= 7'd1;
                        r_stored <= '0;
                    end else begin
                        r_cnt[disp] <= cnt_inc;
                        r_ocat      <= cnt_inc;
                        if ((r_kind == dpdm_pkg::KIND_HIGH) && (r_stored < CW'(MAX_OBJECTS))) begin
                            r_stored <= r_stored + CW'(1);
                        end
                    end
                end
            end
        end
    end

    assign o_valid          = r_ovalid;
    assign o_disposition    = r_odisp;
    assign o_category_count = r_ocat;
    assign o_tracker_count  = r_otrk;
    assign o_error_flag     = r_oerr;

endmodule

### rtl/dual_pass_detection_merge.sv
// top level of the dual-pass detection merge
//
// merges the high-pass and low-pass detection lists of one frame. a frame
// start word clears the box table and all counters; a high-pass box is
// stored and counted as a tracker candidate; a low-pass box gets exactly one
// disposition (below low, duplicate, rejected, suppressed, capacity dropped,
// accepted). overlap is intersection*65536 > iou_limit*union with a
// nonzero union, against same-class stored high-pass boxes only. one item is
// in work at a time. frame starts, high-pass boxes and boxes that need no
// table scan go straight to the result; a low-pass box that scans reads
// its stored boxes through the single read port of the box table (one entry
// per cycle) into the overlap pipeline behind it, which drains before the
// result. the result sits in an output register, so the next word is taken
// while the previous result waits. an invalid configuration (low >= high,
// or a threshold above 1.0) flags every word as an error and ignores it.
// config writes are always ready and must be made only while idle.
module dual_pass_detection_merge #(
    parameter int MAX_OBJECTS = dpdm_pkg::MAX_OBJECTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [16:0]         i_cfg_data,
    // input words
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_class_label,
    input  logic [16:0]         i_score,
    input  logic signed [15:0]  i_box_left,
    input  logic signed [15:0]  i_box_top,
    input  logic signed [15:0]  i_box_right,
    input  logic signed [15:0]  i_box_bottom,
    // result words
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_disposition,
    output logic [6:0]          o_category_count,
    output logic [6:0]          o_tracker_count,
    output logic                o_error_flag
);

    localparam int CW = $clog2(MAX_OBJECTS + 1);
    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

    dpdm_pkg::t_cmd cmd;
    dpdm_pkg::t_sts sts;
    logic [AW-1:0]  rd_addr;
    logic [CW-1:0]  stored_count;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencing of each word and of the table scan
    dpdm_ctrl #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sts          (sts),
        .i_stored_count (stored_count),
        .o_cmd          (cmd),
        .o_rd_addr      (rd_addr)
    );

    // table, overlap test, counters and result register
    dpdm_dp #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_class_label    (i_class_label),
        .i_score          (i_score),
        .i_box_left       (i_box_left),
        .i_box_top        (i_box_top),
        .i_box_right      (i_box_right),
        .i_box_bottom     (i_box_bottom),
        .i_cmd            (cmd),
        .i_rd_addr        (rd_addr),
        .o_sts            (sts),
        .o_stored_count   (stored_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_disposition    (o_disposition),
        .o_category_count (o_category_count),
        .o_tracker_count  (o_tracker_count),
        .o_error_flag     (o_error_flag)
    );

endmodule

### dv/dual_pass_detection_merge_checker.sv
// checker: watches both channels, predicts each result word and compares it
`timescale 1ns / 100ps
module dual_pass_detection_merge_checker #(
    parameter int MAX_OBJECTS = dpdm_pkg::MAX_OBJECTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_class_label,
    input  logic [16:0]        i_score,
    input  logic signed [15:0] i_box_left,
    input  logic signed [15:0] i_box_top,
    input  logic signed [15:0] i_box_right,
    input  logic signed [15:0] i_box_bottom,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_disposition,
    input  logic [6:0]         i_category_count,
    input  logic [6:0]         i_tracker_count,
    input  logic               i_error_flag,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_seen
);

    typedef struct packed {
        logic [2:0] disp;
        logic [6:0] cat;
        logic [6:0] trk;
        logic       err;
    } t_word;

    typedef struct {
        longint l, t, r, b;
    } t_rect;

    t_word   result_fifo[$];
    t_rect   table_rect[MAX_OBJECTS];
    logic [7:0] table_cls[MAX_OBJECTS];
    int      table_fill, cand_total;
    int      disp_cnt[8];
    longint  thr_low, thr_high, thr_ovl;

    function automatic longint span_of(longint lo, longint hi);
        return hi > lo ? hi - lo : 0;
    endfunction

    function automatic bit iou_hit(t_rect a, t_rect b);
        longint inter, ua;
        inter = span_of(a.l > b.l ? a.l : b.l, a.r < b.r ? a.r : b.r)
              * span_of(a.t > b.t ? a.t : b.t, a.b < b.b ? a.b : b.b);
        ua = span_of(a.l, a.r) * span_of(a.t, a.b)
           + span_of(b.l, b.r) * span_of(b.t, b.b) - inter;
        if (ua == 0) return 0;
        return inter * 65536 > thr_ovl * ua;
    endfunction

    function automatic bit hits_table(t_rect r, logic [7:0] c);
        for (int i = 0; i < table_fill; i++)
            if (table_cls[i] == c && iou_hit(r, table_rect[i])) return 1;
        return 0;
    endfunction

    function automatic logic [6:0] clip7(int v);
        return v > 127 ? 7'd127 : 7'(v);
    endfunction

    function automatic t_word count_as(logic [2:0] d);
        t_word w;
        if (disp_cnt[d] < 127) disp_cnt[d]++;
        w.disp = d;
        w.cat  = clip7(disp_cnt[d]);
        w.trk  = clip7(cand_total);
        w.err  = 1'b0;
        return w;
    endfunction

    // computes the result word of one accepted input word
    function automatic t_word merge_word();
        t_rect r;
        t_word w;
        bit    cfg_ok;
        cfg_ok = thr_low < thr_high && thr_high <= 65536 && thr_ovl <= 65536;
        r.l = i_box_left; r.t = i_box_top; r.r = i_box_right; r.b = i_box_bottom;
        if (!cfg_ok || i_kind == dpdm_pkg::KIND_UNKNOWN
                || (i_kind == dpdm_pkg::KIND_HIGH && cand_total >= MAX_OBJECTS)) begin
            w = '{disp: dpdm_pkg::DISP_STARTED, cat: 7'd0, trk: clip7(cand_total), err: 1'b1};
            return w;
        end
        if (i_kind == dpdm_pkg::KIND_FRAME) begin
            table_fill = 0;
            cand_total = 0;
            for (int i = 0; i < 8; i++) disp_cnt[i] = 0;
            return count_as(dpdm_pkg::DISP_STARTED);
        end
        if (i_kind == dpdm_pkg::KIND_HIGH) begin
            if (table_fill < MAX_OBJECTS) begin
                table_rect[table_fill] = r;
                table_cls[table_fill] = i_class_label;
                table_fill++;
            end
            cand_total++;
            return count_as(dpdm_pkg::DISP_HIGH_KEPT);
        end
        if (i_score < thr_low) return count_as(dpdm_pkg::DISP_BELOW_LOW);
        if (i_score >= thr_high)
            return count_as(hits_table(r, i_class_label) ? dpdm_pkg::DISP_DUPLICATE
                                                         : dpdm_pkg::DISP_REJECTED);
        if (hits_table(r, i_class_label)) return count_as(dpdm_pkg::DISP_SUPPRESS);
        if (cand_total >= MAX_OBJECTS) return count_as(dpdm_pkg::DISP_CAP_DROP);
        cand_total++;
        return count_as(dpdm_pkg::DISP_ACCEPTED);
    endfunction

    always @(posedge i_clk) begin
        t_word got, want;
        if (!i_rst_n) begin
            result_fifo.delete();
            table_fill = 0;
            cand_total = 0;
            for (int i = 0; i < 8; i++) disp_cnt[i] = 0;
            thr_low = 0; thr_high = 65536; thr_ovl = 32768;
            o_fail_count <= 0;
            o_seen <= 0;
        end else begin
            // result side first: a result never stems from the same edge's input
            if (i_out_valid && !i_out_stall) begin
                got = '{i_disposition, i_category_count, i_tracker_count, i_error_flag};
                o_seen <= o_seen + 1;
                if (result_fifo.size() == 0) begin
                    $display("%0t: unexpected result word %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = result_fifo.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    dpdm_pkg::CFG_LOW_THR:  thr_low = i_cfg_data;
                    dpdm_pkg::CFG_HIGH_THR: thr_high = i_cfg_data;
                    dpdm_pkg::CFG_OVL_THR:  thr_ovl = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) result_fifo.push_back(merge_word());
        end
    end

    assign o_pending = result_fifo.size();

endmodule

### dv/dual_pass_detection_merge_test.sv
// testbench top: drives frames of detection words and config writes, gives the verdict
`timescale 1ns / 100ps
module dual_pass_detection_merge_test;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [16:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         kind = '0;
    logic [7:0]         class_label = '0;
    logic [16:0]        score = '0;
    logic signed [15:0] box_left = '0, box_top = '0, box_right = '0, box_bottom = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         disposition;
    logic [6:0]         category_count, tracker_count;
    logic               error_flag;
    int                 fail_count, pending, seen;
    int                 cycles = 0;
    int                 words_sent = 0;
    bit                 idle_on = 1'b1;   // random idling allowed
    int                 hold_off = 0;     // long receiver stall in cycles

    always #5 i_clk = ~i_clk;

    dual_pass_detection_merge dut (
        .i_clk, .i_rst_n,
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_kind(kind), .i_class_label(class_label), .i_score(score),
        .i_box_left(box_left), .i_box_top(box_top),
        .i_box_right(box_right), .i_box_bottom(box_bottom),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_disposition(disposition), .o_category_count(category_count),
        .o_tracker_count(tracker_count), .o_error_flag(error_flag)
    );

    dual_pass_detection_merge_checker u_checker (
        .i_clk, .i_rst_n,
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_class_label(class_label), .i_score(score),
        .i_box_left(box_left), .i_box_top(box_top),
        .i_box_right(box_right), .i_box_bottom(box_bottom),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_disposition(disposition), .i_category_count(category_count),
        .i_tracker_count(tracker_count), .i_error_flag(error_flag),
        .o_fail_count(fail_count), .o_pending(pending), .o_seen(seen)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("dual_pass_detection_merge regression: fail");
            $finish;
        end
    end

    // receiver stall: random bursts, or a long hold-off when asked
    always @(posedge i_clk) begin
        int burst;
        if (hold_off > 0) begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else if (burst > 0) begin
            burst = burst - 1;
            out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // one word to the block; random gap before it, valid stays up after acceptance
    // until the next word or until the sender goes quiet
    task automatic send_word(logic [1:0] k, logic [7:0] c, logic [16:0] s,
                             logic signed [15:0] l, logic signed [15:0] t,
                             logic signed [15:0] r, logic signed [15:0] b);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        kind <= k; class_label <= c; score <= s;
        box_left <= l; box_top <= t; box_right <= r; box_bottom <= b;
        do @(posedge i_clk); while (in_stall);
        words_sent++;
    endtask

    // sender goes quiet, waits until every expected result has come, then for the drain
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (dpdm_pkg::MAX_OBJECTS_DEF + 20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic set_thresholds(logic [16:0] lo, logic [16:0] hi, logic [16:0] ov);
        wait_drained();
        write_reg(dpdm_pkg::CFG_LOW_THR, lo);
        write_reg(dpdm_pkg::CFG_HIGH_THR, hi);
        write_reg(dpdm_pkg::CFG_OVL_THR, ov);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [16:0] rand_score();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return dpdm_pkg::Q_ONE;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // a box, mostly placed near a small set of anchors so overlaps are frequent
    task automatic rand_box(output logic signed [15:0] l, output logic signed [15:0] t,
                            output logic signed [15:0] r, output logic signed [15:0] b);
        int x, y;
        if ($urandom_range(0, 9) == 0) begin
            l = 16'($urandom); t = 16'($urandom); r = 16'($urandom); b = 16'($urandom);
        end else begin
            x = $urandom_range(0, 3) * 40 - 60 + $urandom_range(0, 8);
            y = $urandom_range(0, 3) * 40 - 60 + $urandom_range(0, 8);
            l = 16'(x); t = 16'(y);
            r = 16'(x + $urandom_range(0, 50));
            b = 16'(y + $urandom_range(0, 50));
        end
    endtask

    // one frame: start word, high-pass boxes, low-pass boxes, some noise
    task automatic run_frame(int n_high, int n_low);
        logic signed [15:0] l, t, r, b;
        send_word(dpdm_pkg::KIND_FRAME, 8'($urandom), 17'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
        for (int i = 0; i < n_high; i++) begin
            rand_box(l, t, r, b);
            send_word(dpdm_pkg::KIND_HIGH, 8'($urandom_range(0, 2)), rand_score(), l, t, r, b);
        end
        for (int i = 0; i < n_low; i++) begin
            rand_box(l, t, r, b);
            if ($urandom_range(0, 19) == 0)
                send_word(dpdm_pkg::KIND_UNKNOWN, 8'($urandom), rand_score(), l, t, r, b);
            else
                send_word(dpdm_pkg::KIND_LOW, 8'($urandom_range(0, 2)), rand_score(),
                          l, t, r, b);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default thresholds, frame, field extremes and each disposition but capacity drop
        send_word(dpdm_pkg::KIND_HIGH, 8'd0, 17'd0, 16'sd0, 16'sd0, 16'sd10, 16'sd10);
        send_word(dpdm_pkg::KIND_FRAME, 8'hff, dpdm_pkg::Q_ONE, 16'sh7fff, 16'sh7fff,
                  -16'sd32768, -16'sd32768);
        send_word(dpdm_pkg::KIND_HIGH, 8'hff, dpdm_pkg::Q_ONE, -16'sd32768, -16'sd32768,
                  16'sh7fff, 16'sh7fff);
        send_word(dpdm_pkg::KIND_HIGH, 8'd5, 17'd100, 16'sd0, 16'sd0, 16'sd10, 16'sd10);
        // zero area
        send_word(dpdm_pkg::KIND_HIGH, 8'd6, 17'd100, 16'sd5, 16'sd5, 16'sd5, 16'sd9);
        // duplicate
        send_word(dpdm_pkg::KIND_LOW, 8'd5, dpdm_pkg::Q_ONE, 16'sd0, 16'sd0, 16'sd10, 16'sd10);
        // rejected
        send_word(dpdm_pkg::KIND_LOW, 8'd5, dpdm_pkg::Q_ONE, 16'sd50, 16'sd50,
                  16'sd60, 16'sd60);
        // suppressed
        send_word(dpdm_pkg::KIND_LOW, 8'd5, 17'd500, 16'sd1, 16'sd0, 16'sd11, 16'sd10);
        // other class
        send_word(dpdm_pkg::KIND_LOW, 8'd7, 17'd500, 16'sd1, 16'sd0, 16'sd11, 16'sd10);
        // zero union
        send_word(dpdm_pkg::KIND_LOW, 8'd6, 17'd500, 16'sd5, 16'sd5, 16'sd5, 16'sd9);
        send_word(dpdm_pkg::KIND_LOW, 8'hff, 17'd1, 16'sh7fff, -16'sd32768, -16'sd32768,
                  16'sh7fff);
        // unknown kind
        send_word(dpdm_pkg::KIND_UNKNOWN, 8'd0, 17'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        set_thresholds(17'd1000, 17'd60000, 17'd0);
        // below low, then the edges of each threshold
        send_word(dpdm_pkg::KIND_LOW, 8'd1, 17'd999, 16'sd0, 16'sd0, 16'sd1, 16'sd1);
        send_word(dpdm_pkg::KIND_LOW, 8'd1, 17'd1000, 16'sd0, 16'sd0, 16'sd1, 16'sd1);
        send_word(dpdm_pkg::KIND_LOW, 8'd1, 17'd59999, 16'sd0, 16'sd0, 16'sd1, 16'sd1);
        send_word(dpdm_pkg::KIND_LOW, 8'd1, 17'd60000, 16'sd0, 16'sd0, 16'sd1, 16'sd1);
        // invalid settings: low equal to high, thresholds above one
        set_thresholds(17'd500, 17'd500, 17'd100);
        send_word(dpdm_pkg::KIND_FRAME, 8'd0, 17'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        set_thresholds(17'd0, 17'h1ffff, 17'd100);
        send_word(dpdm_pkg::KIND_LOW, 8'd0, 17'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        set_thresholds(17'd0, dpdm_pkg::Q_ONE, 17'h1ffff);
        send_word(dpdm_pkg::KIND_HIGH, 8'd0, 17'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);

        // capacity: fill the table, then overflow high and low
        set_thresholds(17'd0, dpdm_pkg::Q_ONE, dpdm_pkg::Q_ONE);
        run_frame(66, 4);

        // random frames over several settings, extremes included
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_thresholds(17'd0, dpdm_pkg::Q_ONE, 17'd32768);
                1: set_thresholds(17'd0, 17'd1, 17'd0);
                2: set_thresholds(17'd65535, dpdm_pkg::Q_ONE, dpdm_pkg::Q_ONE);
                3: set_thresholds(17'($urandom_range(0, 30000)),
                                  17'($urandom_range(30001, 65536)),
                                  17'($urandom_range(0, 65536)));
                4: set_thresholds(17'd20000, 17'd50000, 17'd13107);
                default: set_thresholds(17'($urandom_range(0, 30000)),
                                        17'($urandom_range(30001, 65536)),
                                        17'($urandom_range(0, 65536)));
            endcase
            if (phase == 3) begin
                // long receiver hold-off while words keep coming
                fork
                    hold_off = 300;
                    run_frame(6, 20);
                join
            end
            if (phase == 7) idle_on = 1'b0;  // closing stretch runs at full rate
            while (words_sent < 220 + phase * 150)
                run_frame($urandom_range(0, 12), $urandom_range(1, 24));
        end

        wait_drained();
        $display("sent %0d words, checked %0d results across directed, capacity and",
                 words_sent, seen);
        $display("eight threshold settings including invalid and extreme values");
        if (fail_count == 0) begin
            $display("dual_pass_detection_merge regression: pass");
        end else begin
            $display("dual_pass_detection_merge regression: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/dpdm_pkg.sv
rtl/dpdm_ctrl.sv
rtl/dpdm_dp.sv
rtl/dual_pass_detection_merge.sv
dv/dual_pass_detection_merge_checker.sv
dv/dual_pass_detection_merge_test.sv
